FILE: src/ggrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggrm_pkg
// Shared constants, register codes and types of the greedy rectangle merge
// unit.
// ----------------------------------------------------------------------------
package ggrm_pkg;

    localparam int GRID_SIDE_DEF = 8;
    localparam int MAX_RESULTS   = 32;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);

    localparam int COORD_W  = 3;
    localparam int ID_W     = 6;
    localparam int PIX_W    = 11;
    localparam int MASK_W   = 64;
    localparam int CELLPX_W = 8;
    // cell counts on the request bus; the 4-bit field holds counts up to 15
    localparam int CNT_FW   = 4;

    localparam logic [PIX_W-1:0]    PIX_MAX     = 11'd2047;
    localparam logic [CELLPX_W-1:0] CELL_PX_RST = 8'd16;
    localparam logic [MASK_W-1:0]   MASK_RST    = '0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_GEN   = 1'b1;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam logic REG_SOLID_MASK = 1'b0;
    localparam logic REG_CELL_PX    = 1'b1;

    typedef struct packed {
        logic                push;
        logic                flush;
        logic [CNT_FW-1:0]   col;
        logic [CNT_FW-1:0]   row;
        logic [CNT_FW-1:0]   w;
        logic [CNT_FW-1:0]   h;
    } t_rect_req;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] w;
        logic [PIX_W-1:0] h;
    } t_box;

    typedef struct packed {
        logic box_valid;
        t_box box;
        logic last;
    } t_result;

endpackage
`default_nettype wire

FILE: src/ggrm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggrm_in_if
// Command channel: cell writes and generate requests.
// ----------------------------------------------------------------------------
interface ggrm_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [ggrm_pkg::COORD_W-1:0]   cell_x;
    logic [ggrm_pkg::COORD_W-1:0]   cell_y;
    logic [ggrm_pkg::ID_W-1:0]      block_id;

    modport source (output valid, command, cell_x, cell_y, block_id, input ready);
    modport sink   (input valid, command, cell_x, cell_y, block_id, output ready);
endinterface
`default_nettype wire

FILE: src/ggrm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggrm_out_if
// Result channel: one rectangle in pixel units per transfer.
// ----------------------------------------------------------------------------
interface ggrm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           box_valid;
    logic [ggrm_pkg::PIX_W-1:0]     box_x;
    logic [ggrm_pkg::PIX_W-1:0]     box_y;
    logic [ggrm_pkg::PIX_W-1:0]     box_w;
    logic [ggrm_pkg::PIX_W-1:0]     box_h;
    logic                           last;

    modport source (output valid, box_valid, box_x, box_y, box_w, box_h, last,
                    input ready);
    modport sink   (input valid, box_valid, box_x, box_y, box_w, box_h, last,
                    output ready);
endinterface
`default_nettype wire

FILE: src/grid_greedy_rectangle_merge_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_greedy_rectangle_merge_unit
// Grid of block ids merged greedily into solid rectangles on request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            carries
//  i_in      in   valid/ready          command, cell_x, cell_y, block_id
//  o_out     out  valid/ready          box_valid, box_x/y/w/h, last
//  apb       in   psel/penable/pwrite  solid_id_mask @0x0, cell_pixels @0x8
//
//  A cell write is accepted in the idle state; writes can follow back to back.
//  A generate clears the visited memory, primes the first read, then probes
//  the cells one at a time (one read port on the id and visited memories),
//  marks each cell of each rectangle, emits it and reloads the scan position,
//  and finally flushes.
//  After reset a clearing pass over all GRID_SIDE^2 cells zeroes the cell ids;
//  i_in.ready stays low until it ends.
//  A full output register stalls the scan at the emit and flush steps.
// ----------------------------------------------------------------------------
module grid_greedy_rectangle_merge_unit #(
    parameter int GRID_SIDE = ggrm_pkg::GRID_SIDE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    ggrm_in_if.sink                                  i_in,
    ggrm_out_if.source                               o_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ggrm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [ggrm_pkg::CFG_DATA_W-1:0]     pwdata,
    output      logic [ggrm_pkg::CFG_DATA_W-1:0]     prdata,
    output      logic                                pready
);

    logic [ggrm_pkg::MASK_W-1:0]   r_solid_mask;
    logic [ggrm_pkg::CELLPX_W-1:0] r_cell_px;
    logic                          cfg_wr;
    ggrm_pkg::t_rect_req           w_req;
    logic                          w_out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid_mask <= ggrm_pkg::MASK_RST;
            r_cell_px    <= ggrm_pkg::CELL_PX_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                ggrm_pkg::REG_SOLID_MASK: r_solid_mask <= pwdata;
                ggrm_pkg::REG_CELL_PX:    r_cell_px    <= pwdata[ggrm_pkg::CELLPX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            ggrm_pkg::REG_SOLID_MASK: prdata = r_solid_mask;
            ggrm_pkg::REG_CELL_PX:    prdata = ggrm_pkg::CFG_DATA_W'(r_cell_px);
            default:                  prdata = '0;
        endcase
    end

    ggrm_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_solid_mask (r_solid_mask),
        .i_out_free   (w_out_free),
        .o_req        (w_req)
    );

    ggrm_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_cell_px (r_cell_px),
        .o_free    (w_out_free),
        .o_out     (o_out)
    );

    // a request is only raised when the output register can take a transfer
    a_req_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.push || w_req.flush) |-> w_out_free)
        else $error("rectangle request while output register busy");

    a_req_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.push && w_req.flush))
        else $error("push and flush in the same cycle");

    a_rect_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.push |-> (w_req.w != '0 && w_req.h != '0))
        else $error("empty rectangle pushed");

    a_flush_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.flush |=> i_in.ready)
        else $error("not ready for commands after a generation");

endmodule
`default_nettype wire

FILE: src/ggrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggrm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ggrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output      logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/ggrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggrm_ctrl
// Scan sequencer: owns the cell id and visited memories, grows rectangles
// one probed cell per cycle and marks them visited.
// ----------------------------------------------------------------------------
module ggrm_ctrl #(
    parameter int GRID_SIDE = ggrm_pkg::GRID_SIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ggrm_in_if.sink                            i_in,
    input  wire logic [ggrm_pkg::MASK_W-1:0]   i_solid_mask,
    input  wire logic                          i_out_free,
    output      ggrm_pkg::t_rect_req           o_req
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE + 1);
    localparam int RW    = ggrm_pkg::RES_W;
    localparam logic [CW:0]   SIDE_X   = (CW+1)'(GRID_SIDE);
    localparam logic [AW-1:0] LAST_ADR = AW'(CELLS - 1);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_VCLR   = 4'd2;
    localparam logic [3:0] S_SEEK   = 4'd3;
    localparam logic [3:0] S_ANCHOR = 4'd4;
    localparam logic [3:0] S_RIGHT  = 4'd5;
    localparam logic [3:0] S_DOWN   = 4'd6;
    localparam logic [3:0] S_MARK   = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;
    localparam logic [3:0] S_FLUSH  = 4'd9;

    function automatic logic [AW-1:0] cell_addr(input logic [CW:0] row,
                                                input logic [CW:0] col);
        return AW'(AW'(row) * AW'(GRID_SIDE) + AW'(col));
    endfunction

    // coordinate modulo the grid side, by repeated subtraction
    function automatic logic [CW:0] wrap(input logic [ggrm_pkg::COORD_W-1:0] x);
        logic [3:0] v;
        v = {1'b0, x};
        for (int k = 0; k < 3; k++) begin
            if (v >= 4'(GRID_SIDE)) begin
                v = v - 4'(GRID_SIDE);
            end
        end
        return (CW+1)'(v);
    endfunction

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_row, n_row, r_col, n_col, r_w, n_w, r_h, n_h;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [RW-1:0] r_cnt, n_cnt;

    logic                          id_we, vis_we, vis_wdata;
    logic [AW-1:0]                 id_waddr, vis_waddr, rd_addr;
    logic [ggrm_pkg::ID_W-1:0]     id_wdata, id_rdata;
    logic                          vis_rdata;
    logic                          open_cell;

    logic [CW:0] col_p1, row_p1, pc, pc_p1, pr, pr_p1, dc, dc_p1, i_p1, j_p1, rj;

    ggrm_ram #(.WIDTH(ggrm_pkg::ID_W), .DEPTH(CELLS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (id_wdata),
        .i_raddr (rd_addr),
        .o_rdata (id_rdata)
    );

    ggrm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (rd_addr),
        .o_rdata (vis_rdata)
    );

    assign open_cell = !vis_rdata && i_solid_mask[id_rdata];

    assign col_p1 = {1'b0, r_col} + (CW+1)'(1);
    assign row_p1 = {1'b0, r_row} + (CW+1)'(1);
    assign pc     = {1'b0, r_col} + {1'b0, r_w};
    assign pc_p1  = pc + (CW+1)'(1);
    assign pr     = {1'b0, r_row} + {1'b0, r_h};
    assign pr_p1  = pr + (CW+1)'(1);
    assign dc     = {1'b0, r_col} + {1'b0, r_i};
    assign dc_p1  = dc + (CW+1)'(1);
    assign i_p1   = {1'b0, r_i} + (CW+1)'(1);
    assign j_p1   = {1'b0, r_j} + (CW+1)'(1);
    assign rj     = {1'b0, r_row} + {1'b0, r_j};

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_row     = r_row;
        n_col     = r_col;
        n_w       = r_w;
        n_h       = r_h;
        n_i       = r_i;
        n_j       = r_j;
        n_cnt     = r_cnt;
        rd_addr   = cell_addr({1'b0, r_row}, {1'b0, r_col});
        id_we     = 1'b0;
        id_waddr  = r_clr;
        id_wdata  = '0;
        vis_we    = 1'b0;
        vis_waddr = r_clr;
        vis_wdata = 1'b0;
        o_req     = '0;
        o_req.col = ggrm_pkg::CNT_FW'(r_col);
        o_req.row = ggrm_pkg::CNT_FW'(r_row);
        o_req.w   = ggrm_pkg::CNT_FW'(r_w);
        o_req.h   = ggrm_pkg::CNT_FW'(r_h);

        unique case (r_state)
            S_CLR: begin
                id_we = 1'b1;
                if (r_clr == LAST_ADR) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.command == ggrm_pkg::CMD_WRITE) begin
                        id_we    = 1'b1;
                        id_waddr = cell_addr(wrap(i_in.cell_y), wrap(i_in.cell_x));
                        id_wdata = i_in.block_id;
                    end else begin
                        n_clr   = '0;
                        n_cnt   = '0;
                        n_state = S_VCLR;
                    end
                end
            end
            S_VCLR: begin
                vis_we = 1'b1;
                if (r_clr == LAST_ADR) begin
                    n_clr   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_SEEK;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_SEEK: begin
                n_state = S_ANCHOR;
            end
            S_ANCHOR: begin
                if (open_cell) begin
                    n_w = CW'(1);
                    n_h = CW'(1);
                    n_i = '0;
                    n_j = '0;
                    if (col_p1 < SIDE_X) begin
                        rd_addr = cell_addr({1'b0, r_row}, col_p1);
                        n_state = S_RIGHT;
                    end else if (row_p1 < SIDE_X) begin
                        rd_addr = cell_addr(row_p1, {1'b0, r_col});
                        n_state = S_DOWN;
                    end else begin
                        n_state = S_MARK;
                    end
                end else if (col_p1 < SIDE_X) begin
                    n_col   = CW'(col_p1);
                    rd_addr = cell_addr({1'b0, r_row}, col_p1);
                end else if (row_p1 < SIDE_X) begin
                    n_row   = CW'(row_p1);
                    n_col   = '0;
                    rd_addr = cell_addr(row_p1, '0);
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_RIGHT: begin
                if (open_cell && pc_p1 < SIDE_X) begin
                    n_w     = r_w + CW'(1);
                    rd_addr = cell_addr({1'b0, r_row}, pc_p1);
                end else begin
                    // run closed: grow downward if a row remains below, else mark
                    if (open_cell) begin
                        n_w = r_w + CW'(1);
                    end
                    if (row_p1 < SIDE_X) begin
                        rd_addr = cell_addr(row_p1, {1'b0, r_col});
                        n_state = S_DOWN;
                    end else begin
                        n_state = S_MARK;
                    end
                end
            end
            S_DOWN: begin
                if (!open_cell) begin
                    n_i     = '0;
                    n_state = S_MARK;
                end else if (i_p1 < {1'b0, r_w}) begin
                    n_i     = CW'(i_p1);
                    rd_addr = cell_addr(pr, dc_p1);
                end else begin
                    n_h = r_h + CW'(1);
                    n_i = '0;
                    if (pr_p1 < SIDE_X) begin
                        rd_addr = cell_addr(pr_p1, {1'b0, r_col});
                    end else begin
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                vis_we    = 1'b1;
                vis_wdata = 1'b1;
                vis_waddr = cell_addr(rj, dc);
                if (i_p1 < {1'b0, r_w}) begin
                    n_i = CW'(i_p1);
                end else begin
                    n_i = '0;
                    if (j_p1 < {1'b0, r_h}) begin
                        n_j = CW'(j_p1);
                    end else begin
                        n_j     = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_req.push = 1'b1;
                    n_cnt      = r_cnt + RW'(1);
                    if ((r_cnt + RW'(1)) == RW'(ggrm_pkg::MAX_RESULTS)) begin
                        n_state = S_FLUSH;
                    end else if (col_p1 < SIDE_X) begin
                        n_col   = CW'(col_p1);
                        n_state = S_SEEK;
                    end else if (row_p1 < SIDE_X) begin
                        n_row   = CW'(row_p1);
                        n_col   = '0;
                        n_state = S_SEEK;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_out_free) begin
                    o_req.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_w   <= n_w;
        r_h   <= n_h;
        r_i   <= n_i;
        r_j   <= n_j;
    end

endmodule
`default_nettype wire

FILE: src/ggrm_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggrm_out
// Pixel scaling, one-deep hold of the newest rectangle (its last flag is
// known only once the scan moves on) and the output register.
// ----------------------------------------------------------------------------
module ggrm_out (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ggrm_pkg::t_rect_req             i_req,
    input  wire logic [ggrm_pkg::CELLPX_W-1:0]   i_cell_px,
    output      logic                            o_free,
    ggrm_out_if.source                           o_out
);

    localparam int PW = ggrm_pkg::CNT_FW + ggrm_pkg::CELLPX_W;

    function automatic logic [ggrm_pkg::PIX_W-1:0] to_px(
        input logic [ggrm_pkg::CNT_FW-1:0]   cells,
        input logic [ggrm_pkg::CELLPX_W-1:0] px
    );
        logic [PW-1:0] prod;
        prod = PW'(cells) * PW'(px);
        return (prod > PW'(ggrm_pkg::PIX_MAX)) ? ggrm_pkg::PIX_MAX
                                              : prod[ggrm_pkg::PIX_W-1:0];
    endfunction

    logic              r_pend_valid, n_pend_valid;
    ggrm_pkg::t_box    r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    ggrm_pkg::t_result r_out, n_out;

    assign o_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        if (i_req.push) begin
            n_pend.x     = to_px(i_req.col, i_cell_px);
            n_pend.y     = to_px(i_req.row, i_cell_px);
            n_pend.w     = to_px(i_req.w, i_cell_px);
            n_pend.h     = to_px(i_req.h, i_cell_px);
            n_pend_valid = 1'b1;
            // a newer rectangle exists, so the held one is not the last
            if (r_pend_valid) begin
                n_out_valid     = 1'b1;
                n_out.box_valid = 1'b1;
                n_out.box       = r_pend;
                n_out.last      = 1'b0;
            end
        end else if (i_req.flush) begin
            n_out_valid     = 1'b1;
            n_out.box_valid = r_pend_valid;
            n_out.box       = r_pend_valid ? r_pend : '0;
            n_out.last      = 1'b1;
            n_pend_valid    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.box_valid = r_out.box_valid;
    assign o_out.box_x     = r_out.box.x;
    assign o_out.box_y     = r_out.box.y;
    assign o_out.box_w     = r_out.box.w;
    assign o_out.box_h     = r_out.box.h;
    assign o_out.last      = r_out.last;

endmodule
`default_nettype wire
